### design/asa_pkg.sv
`timescale 1ns / 1ps
// Shared types and helpers for the anti-aliased snake activation block.
// Used by the activation unit and the top level; depends on nothing.
package asa_pkg;

   // Request into the activation unit: one upsampled value to activate.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] u;
   } act_req_type;

   // Activated value coming back from the activation unit.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] a;
   } act_rsp_type;

   // Clamp a wide signed value into 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      logic signed [15:0] r;
      if (v > 48'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -48'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### design/asa_act.sv
`timescale 1ns / 1ps
// Activation unit: u + inv_beta * sin^2(alpha_gain * u), eight-stage pipeline.
// Holds the quarter-wave sine table; depends on asa_pkg.
module asa_act #(
   parameter int SINE_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         alpha_gain,
   input  logic [15:0]         inv_beta,
   input  asa_pkg::act_req_type act_req,
   output asa_pkg::act_rsp_type act_rsp
);
   import asa_pkg::*;

   localparam int IDX_W = $clog2(SINE_ENTRIES);
   localparam logic [63:0] TWO_SE = 64'(2 * SINE_ENTRIES);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [29:0] INV_TWO_PI_U = 30'd683565276;
   localparam logic signed [30:0] INV_TWO_PI_S = 31'sd683565276;
   localparam logic [12:0] SE_W = 13'(SINE_ENTRIES);
   localparam logic [12:0] SE_M1 = 13'(SINE_ENTRIES - 1);

   // Entry i is sin((i+0.5)*pi/(2*SINE_ENTRIES)) in Q15 by a Taylor series.
   function automatic logic [15:0] sine_entry(input int unsigned i);
      logic [63:0]        th;
      logic [63:0]        term;
      logic signed [63:0] sum;
      th = ((64'(i) * 64'd2 + 64'd1) * HALF_PI_Q30 + 64'(SINE_ENTRIES)) / TWO_SE;
      term = th;
      sum = $signed(th);
      for (int k = 1; k <= 6; k++) begin
         term = (((term * th) >> 30) * th) >> 30;
         case (k)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            default: term = term / 64'd156;
         endcase
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) begin
         sum = 64'sd32767;
      end
      return sum[15:0];
   endfunction

   logic [15:0] rom_tbl [SINE_ENTRIES];

   for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_rom
      assign rom_tbl[gi] = sine_entry(gi);
   end

   logic [7:0]         vld_ff;
   logic signed [15:0] u_pipe_ff [7];
   logic signed [32:0] arg_ff;
   logic [45:0]        prodl_ff;
   logic signed [47:0] prodh_ff;
   logic [31:0]        phase_ff;
   logic [42:0]        idxp_ff;
   logic               mir_ff;
   logic [15:0]        s_ff;
   logic [15:0]        s2_ff;
   logic [21:0]        term_ff;
   logic signed [15:0] a_ff;

   logic signed [32:0] arg_in;
   logic [51:0]        psum;
   logic [12:0]        idx_raw;
   logic [12:0]        idx_fix;
   logic [IDX_W-1:0]   idx_sel;
   logic [31:0]        sq;
   logic [32:0]        amp;

   always_comb begin
      arg_in = $signed({1'b0, alpha_gain}) * act_req.u;
      // Phase bits 51..20 of alpha*u*K; the high half is weighted by 2^16.
      psum = {prodh_ff[35:0], 16'b0} + {6'b0, prodl_ff};
      idx_raw = idxp_ff[42:30];
      idx_fix = (idx_raw >= SE_W) ? SE_M1 : idx_raw;
      if (mir_ff) begin
         idx_fix = SE_M1 - idx_fix;
      end
      idx_sel = idx_fix[IDX_W-1:0];
      sq = s_ff * s_ff;
      amp = {17'b0, inv_beta} * {17'b0, s2_ff} + 33'd1024;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], act_req.valid};
      end
   end

   always_ff @(posedge clock) begin
      u_pipe_ff[0] <= act_req.u;
      for (int i = 1; i < 7; i++) begin
         u_pipe_ff[i] <= u_pipe_ff[i-1];
      end
      arg_ff   <= arg_in;
      prodl_ff <= arg_ff[15:0] * INV_TWO_PI_U;
      prodh_ff <= $signed(arg_ff[32:16]) * INV_TWO_PI_S;
      phase_ff <= psum[51:20];
      idxp_ff  <= phase_ff[29:0] * SE_W;
      mir_ff   <= phase_ff[30];
      s_ff     <= rom_tbl[idx_sel];
      s2_ff    <= 16'((sq + 32'd16384) >> 15);
      term_ff  <= amp[32:11];
      a_ff     <= sat16({{32{u_pipe_ff[6][15]}}, u_pipe_ff[6]} + {26'b0, term_ff});
   end

   assign act_rsp.valid = vld_ff[7];
   assign act_rsp.a     = a_ff;

endmodule

### design/anti_aliased_snake_activation.sv
`timescale 1ns / 1ps
// Top level of the anti-aliased snake activation: stream control, tap and
// history memories, the polyphase MAC sequencer and the output register.
// Depends on asa_pkg and asa_act.
//
//   Channel | Direction | Transaction carries
//   --------+-----------+-----------------------------------------------------
//   req_    | in        | tuser=func, tdata={value,tap_index}, tlast=is_last
//   rsp_    | out       | tdata=out_sample, tlast=out_last
//   csr_    | in        | index 0 alpha_gain, index 1 inv_beta, written at once
//
// A tap load, an ignored item and a sample that gives no result are each
// taken in ST_IDLE without leaving it. Each result is built per down tap
// from a setup step (ST_KSTART), the TAPS/RATIO up-tap issues (ST_UP), the
// drain (ST_DRAIN), the activation pipeline (ST_ACT) and the down MAC
// (ST_DN, ST_DNACC); ST_NSTART comes before the first tap, ST_OUT after.
// A last sample gives up to DELAY+1 results back to back in that way.
// Reset is synchronous; the taps are undefined until loaded. The next item is
// taken once the last result is in the output register, even while it waits.
module anti_aliased_snake_activation #(
   parameter int TAPS         = 12,
   parameter int RATIO        = 2,
   parameter int SINE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [4:0] tap_index, [20:5] value, [23:21] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_sample
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import asa_pkg::*;

   // Filter geometry, all fixed at elaboration.
   localparam int UP_PAD   = TAPS / RATIO - 1;
   localparam int UP_LEAD  = UP_PAD * RATIO + (TAPS - RATIO) / 2;
   localparam int DN_LEAD  = TAPS / 2 - 1;
   localparam int DN_REACH = TAPS - 1 - DN_LEAD;
   localparam int DELAY    = (DN_REACH + UP_LEAD) / RATIO - UP_PAD;
   localparam int HIST     = 4 * TAPS / RATIO + 4;
   localparam int UA       = UP_LEAD / RATIO;
   localparam int UB       = UP_LEAD % RATIO;
   localparam int DNF      = (DN_LEAD + RATIO - 1) / RATIO;
   localparam int DB0      = DNF * RATIO - DN_LEAD;

   localparam int TAP_AW  = $clog2(TAPS);
   localparam int HIST_AW = $clog2(HIST);
   localparam int KK_W    = $clog2(TAPS + RATIO);
   localparam int S_W     = $clog2(2 * RATIO);
   localparam int POS_W   = 10;

   localparam logic signed [POS_W-1:0] UP_PAD_S = POS_W'(UP_PAD);
   localparam logic signed [POS_W-1:0] UA_S     = POS_W'(UA);
   localparam logic signed [POS_W-1:0] DNF_S    = POS_W'(DNF);
   localparam logic signed [POS_W-1:0] DELAY_S  = POS_W'(DELAY);
   localparam logic signed [POS_W-1:0] POS_ONE  = POS_W'(1);
   localparam logic signed [42:0]      RATIO_S  = 43'(RATIO);

   localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
   localparam logic [1:0] FUNC_UP_TAP  = 2'd1;
   localparam logic [1:0] FUNC_DN_TAP  = 2'd2;
   localparam logic [0:0] REG_ALPHA    = 1'd0;
   localparam logic [0:0] REG_INV_BETA = 1'd1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_NSTART = 9'b000000010,
      ST_KSTART = 9'b000000100,
      ST_UP     = 9'b000001000,
      ST_DRAIN  = 9'b000010000,
      ST_ACT    = 9'b000100000,
      ST_DN     = 9'b001000000,
      ST_DNACC  = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_FIRST,
      SRC_HIST
   } src_type;

   // Request fields.
   logic [1:0]         req_func;
   logic [4:0]         req_idx;
   logic signed [15:0] req_value;
   assign req_func  = req_tuser;
   assign req_idx   = req_tdata[4:0];
   assign req_value = $signed(req_tdata[20:5]);

   // Memories.
   logic signed [15:0] up_mem   [TAPS];
   logic signed [15:0] dn_mem   [TAPS];
   logic signed [15:0] hist_mem [HIST];
   logic signed [15:0] up_rd_ff;
   logic signed [15:0] dn_rd_ff;
   logic signed [15:0] hist_rd_ff;

   // Control registers.
   state_type          state_ff, state_in;
   logic [15:0]        alpha_ff, alpha_in;
   logic [15:0]        inv_ff, inv_in;
   logic               started_ff, started_in;
   logic [7:0]         count_ff, count_in;
   logic               p1_v_ff, p1_v_in;
   logic               p2_v_ff, p2_v_in;
   logic               rsp_v_ff, rsp_v_in;

   // Payload registers.
   logic [HIST_AW-1:0]     newest_ff, newest_in;
   logic signed [15:0]     first_ff, first_in;
   logic [7:0]             cur_c_ff, cur_c_in;
   logic                   cur_last_ff, cur_last_in;
   logic signed [POS_W-1:0] n_ff, n_in;
   logic [TAP_AW-1:0]      k_ff, k_in;
   logic signed [POS_W-1:0] pos_a_ff, pos_a_in;
   logic [S_W-1:0]         pos_b_ff, pos_b_in;
   logic [KK_W-1:0]        kk_ff, kk_in;
   logic signed [POS_W-1:0] q_ff, q_in;
   logic signed [39:0]     acc_up_ff, acc_up_in;
   logic signed [39:0]     acc_dn_ff, acc_dn_in;
   src_type                p1_src_ff, p1_src_in;
   logic signed [31:0]     prod_up_ff, prod_up_in;
   logic signed [31:0]     dn_prod_ff, dn_prod_in;
   logic signed [15:0]     act_a_ff, act_a_in;
   logic [15:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Memory write controls.
   logic               up_we, dn_we, hist_we;
   logic [TAP_AW-1:0]  tap_wa;
   logic [HIST_AW-1:0] hist_wa;
   logic [HIST_AW-1:0] hist_ra;

   // Helpers.
   logic                    accept;
   logic signed [POS_W-1:0] negc;
   logic signed [POS_W-1:0] am;
   logic [S_W-1:0]          bm;
   logic [S_W-1:0]          s_sum;
   logic                    s_ex;
   src_type                 src;
   logic [POS_W-1:0]        hist_back;
   logic [POS_W-1:0]        ring;
   logic [HIST_AW-1:0]      hist_next;
   logic [7:0]              new_c;
   logic signed [15:0]      operand;
   logic signed [42:0]      up_scaled;
   logic signed [42:0]      up_round;
   logic signed [15:0]      u_val;
   logic signed [39:0]      dn_round;
   logic signed [15:0]      out_val;
   logic                    out_free;

   act_req_type act_req;
   act_rsp_type act_rsp;

   asa_act #(
      .SINE_ENTRIES(SINE_ENTRIES)
   ) u_act (
      .clock      (clock),
      .reset      (reset),
      .alpha_gain (alpha_ff),
      .inv_beta   (inv_ff),
      .act_req    (act_req),
      .act_rsp    (act_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Position of the current down tap, clamped at the stream edges, and the
   // first upsampling phase that lands on an input sample.
   always_comb begin
      negc = -$signed(POS_W'(cur_c_ff));
      am = pos_a_ff;
      bm = pos_b_ff;
      if (pos_a_ff < negc) begin
         am = negc;
         bm = '0;
      end else if (cur_last_ff && (pos_a_ff >= POS_ONE)) begin
         am = '0;
         bm = S_W'(RATIO - 1);
      end
      s_sum = bm + S_W'(UB);
      s_ex  = 1'b0;
      if (s_sum >= S_W'(RATIO)) begin
         s_sum = s_sum - S_W'(RATIO);
         s_ex  = 1'b1;
      end
   end

   // Input sample fetch with edge padding.
   always_comb begin
      src  = SRC_ZERO;
      hist_back = POS_W'(-q_ff);
      ring = POS_W'(newest_ff) + POS_W'(HIST) - hist_back;
      if (ring >= POS_W'(HIST)) begin
         ring = ring - POS_W'(HIST);
      end
      hist_ra = ring[HIST_AW-1:0];
      if (q_ff < negc - UP_PAD_S) begin
         src = SRC_ZERO;
      end else if (q_ff < negc) begin
         src = SRC_FIRST;
      end else if (q_ff > 0) begin
         hist_ra = newest_ff;
         src = (cur_last_ff && (q_ff <= UP_PAD_S)) ? SRC_HIST : SRC_ZERO;
      end else begin
         src = SRC_HIST;
      end
   end

   // Datapath arithmetic.
   always_comb begin
      case (p1_src_ff)
         SRC_FIRST: operand = first_ff;
         SRC_HIST:  operand = hist_rd_ff;
         default:   operand = '0;
      endcase
      up_scaled = {{3{acc_up_ff[39]}}, acc_up_ff} * RATIO_S;
      up_round  = (up_scaled + 43'sd8192) >>> 14;
      u_val     = sat16({{5{up_round[42]}}, up_round});
      dn_round  = (acc_dn_ff + 40'sd8192) >>> 14;
      out_val   = sat16({{8{dn_round[39]}}, dn_round});
      out_free  = !rsp_v_ff || rsp_tready;
      hist_next = (newest_ff == HIST_AW'(HIST - 1)) ? '0 : newest_ff + 1'b1;
      new_c     = started_ff ? ((count_ff == 8'd255) ? count_ff : count_ff + 8'd1) : 8'd0;
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      alpha_in    = alpha_ff;
      inv_in      = inv_ff;
      started_in  = started_ff;
      count_in    = count_ff;
      newest_in   = newest_ff;
      first_in    = first_ff;
      cur_c_in    = cur_c_ff;
      cur_last_in = cur_last_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      pos_a_in    = pos_a_ff;
      pos_b_in    = pos_b_ff;
      kk_in       = kk_ff;
      q_in        = q_ff;
      acc_up_in   = acc_up_ff;
      acc_dn_in   = acc_dn_ff;
      p1_v_in     = 1'b0;
      p1_src_in   = src;
      p2_v_in     = p1_v_ff;
      prod_up_in  = up_rd_ff * operand;
      dn_prod_in  = dn_prod_ff;
      act_a_in    = act_a_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_v_in    = rsp_tready ? 1'b0 : rsp_v_ff;
      up_we       = 1'b0;
      dn_we       = 1'b0;
      hist_we     = 1'b0;
      tap_wa      = req_idx[TAP_AW-1:0];
      hist_wa     = started_ff ? hist_next : '0;
      act_req.valid = 1'b0;
      act_req.u     = u_val;

      if (csr_we) begin
         unique case (csr_index)
            REG_ALPHA:    alpha_in = csr_wdata;
            REG_INV_BETA: inv_in   = csr_wdata;
            default:      alpha_in = alpha_ff;
         endcase
      end

      if (p2_v_ff) begin
         acc_up_in = acc_up_ff + {{8{prod_up_ff[31]}}, prod_up_ff};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_UP_TAP: up_we = ({1'b0, req_idx} < 6'(TAPS));
                  FUNC_DN_TAP: dn_we = ({1'b0, req_idx} < 6'(TAPS));
                  FUNC_SAMPLE: begin
                     hist_we     = 1'b1;
                     newest_in   = hist_wa;
                     cur_c_in    = new_c;
                     cur_last_in = req_tlast;
                     if (!started_ff) begin
                        first_in = req_value;
                     end
                     if (req_tlast) begin
                        started_in = 1'b0;
                        count_in   = '0;
                        n_in = (new_c < 8'(DELAY)) ? -$signed(POS_W'(new_c)) : -DELAY_S;
                        state_in = ST_NSTART;
                     end else begin
                        started_in = 1'b1;
                        count_in   = new_c;
                        n_in       = -DELAY_S;
                        if (new_c >= 8'(DELAY)) begin
                           state_in = ST_NSTART;
                        end
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_NSTART: begin
            k_in      = '0;
            pos_a_in  = n_ff - DNF_S;
            pos_b_in  = S_W'(DB0);
            acc_dn_in = '0;
            state_in  = ST_KSTART;
         end
         ST_KSTART: begin
            kk_in     = KK_W'(s_sum);
            q_in      = am + UA_S + POS_W'(s_ex) - UP_PAD_S;
            acc_up_in = '0;
            state_in  = ST_UP;
         end
         ST_UP: begin
            // One tap of the active polyphase branch is issued per cycle.
            p1_v_in = 1'b1;
            kk_in   = kk_ff + KK_W'(RATIO);
            q_in    = q_ff - POS_ONE;
            if (kk_ff + KK_W'(RATIO) >= KK_W'(TAPS)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff) begin
               act_req.valid = 1'b1;
               state_in      = ST_ACT;
            end
         end
         ST_ACT: begin
            if (act_rsp.valid) begin
               act_a_in = act_rsp.a;
               state_in = ST_DN;
            end
         end
         ST_DN: begin
            dn_prod_in = dn_rd_ff * act_a_ff;
            state_in   = ST_DNACC;
         end
         ST_DNACC: begin
            acc_dn_in = acc_dn_ff + {{8{dn_prod_ff[31]}}, dn_prod_ff};
            if (k_ff == TAP_AW'(TAPS - 1)) begin
               state_in = ST_OUT;
            end else begin
               k_in = k_ff + 1'b1;
               if (pos_b_ff == S_W'(RATIO - 1)) begin
                  pos_b_in = '0;
                  pos_a_in = pos_a_ff + POS_ONE;
               end else begin
                  pos_b_in = pos_b_ff + 1'b1;
               end
               state_in = ST_KSTART;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_data_in = out_val;
               rsp_last_in = cur_last_ff && (n_ff == '0);
               if (cur_last_ff && (n_ff != '0)) begin
                  n_in     = n_ff + POS_ONE;
                  state_in = ST_NSTART;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (up_we) begin
         up_mem[tap_wa] <= req_value;
      end
      up_rd_ff <= up_mem[kk_ff[TAP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dn_we) begin
         dn_mem[tap_wa] <= req_value;
      end
      dn_rd_ff <= dn_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= req_value;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         alpha_ff   <= 16'd256;
         inv_ff     <= 16'd256;
         started_ff <= 1'b0;
         count_ff   <= '0;
         p1_v_ff    <= 1'b0;
         p2_v_ff    <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         alpha_ff   <= alpha_in;
         inv_ff     <= inv_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         p1_v_ff    <= p1_v_in;
         p2_v_ff    <= p2_v_in;
         rsp_v_ff   <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff   <= newest_in;
      first_ff    <= first_in;
      cur_c_ff    <= cur_c_in;
      cur_last_ff <= cur_last_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      pos_a_ff    <= pos_a_in;
      pos_b_ff    <= pos_b_in;
      kk_ff       <= kk_in;
      q_ff        <= q_in;
      acc_up_ff   <= acc_up_in;
      acc_dn_ff   <= acc_dn_in;
      p1_src_ff   <= p1_src_in;
      prod_up_ff  <= prod_up_in;
      dn_prod_ff  <= dn_prod_in;
      act_a_ff    <= act_a_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
